>>> hw/rtl/sorted_unique_set_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted unique set table: assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_SET_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_SET_TABLE_DEFINES_SVH

// The property must hold in the same cycle as the trigger.
`define SUST_ASSERT_IMPLY(lbl, trig, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error("sorted set table: assertion failed");

// The property must hold in the cycle after the trigger.
`define SUST_ASSERT_NEXT(lbl, trig, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("sorted set table: assertion failed");

`endif

>>> hw/rtl/sust_pkg.sv
// ----------------------------------------------------------------------------
// Sorted unique set table: package
// Field widths, operation and status codes, and the controller command type.
// ----------------------------------------------------------------------------
package sust_pkg;

   localparam int DEFAULT_CAPACITY = 8;
   localparam int FUNC_W           = 2;
   localparam int VALUE_W          = 32;
   localparam int STATUS_W         = 2;
   localparam int POSITION_W       = 3;
   localparam int COUNT_W          = 4;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_REMOVE  = 2'd1,
      FUNC_REPLACE = 2'd2,
      FUNC_SEARCH  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_FULL    = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request and compare it against the table
      logic commit;    // apply the update and load the result register
   } cmd_type;

endpackage

>>> hw/rtl/sust_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted unique set table: controller
// Two-state sequencer: take a request, then commit it once the result
// register is free. Owns the handshake on both channels.
// ----------------------------------------------------------------------------
module sust_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sust_pkg::cmd_type cmd
);
   import sust_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new item if empty or being drained now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/sust_dp.sv
// ----------------------------------------------------------------------------
// Sorted unique set table: datapath
// Holds the sorted entries and the count, compares a request against every
// entry at once, then shifts the cells to remove and/or insert in one step.
// ----------------------------------------------------------------------------
`include "sorted_unique_set_table_defines.svh"

module sust_dp #(
   parameter int CAPACITY = sust_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sust_pkg::cmd_type                cmd,
   input  logic [sust_pkg::FUNC_W-1:0]      req_func,
   input  sust_pkg::value_type              req_value,
   input  sust_pkg::value_type              req_new_value,
   output logic [sust_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_found,
   output logic [sust_pkg::POSITION_W-1:0]  rsp_position,
   output logic [sust_pkg::COUNT_W-1:0]     rsp_count
);
   import sust_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // Table storage and compare results.
   value_type               entries_ff [CAPACITY];
   value_type               entries_in [CAPACITY];
   value_type               up_src     [CAPACITY];
   value_type               dn_src     [CAPACITY];
   logic [CNT_W-1:0]        count_ff, count_in;
   func_type                func_ff;
   value_type               key_ff;
   logic [CAPACITY-1:0]     key_match_ff, key_match_in;
   logic [CAPACITY-1:0]     new_match_ff, new_match_in;
   logic [CAPACITY-1:0]     lt_ff, lt_in;
   logic [CAPACITY:0]       lt_prev;
   value_type               ins_key;

   // Decision signals.
   logic                    key_hit, new_hit, full;
   logic                    do_ins, do_rem, hit_found;
   status_type              status;
   logic [CNT_W-1:0]        old_idx, bound_idx, rem_idx, ins_idx;
   logic                    rem_before_ins;
   logic [EXT_W-1:0]        pos_ext, cnt_ext;
   logic                    sorted_ok;

   // Result register.
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic                    rsp_found_ff;
   logic [POSITION_W-1:0]   rsp_position_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   // ---------------- compare stage ----------------
   assign ins_key = (func_type'(req_func) == FUNC_REPLACE) ? req_new_value : req_value;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_match_in[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == req_value);
         new_match_in[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == req_new_value);
         lt_in[i]        = (CNT_W'(i) < count_ff) && (entries_ff[i] < ins_key);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff      <= func_type'(req_func);
         key_ff       <= ins_key;
         key_match_ff <= key_match_in;
         new_match_ff <= new_match_in;
         lt_ff        <= lt_in;
      end
   end

   // ---------------- decision stage ----------------
   assign key_hit = |key_match_ff;
   assign new_hit = |new_match_ff;
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign lt_prev = {lt_ff, 1'b1};

   // Values are distinct, so the match vector is one-hot or zero and the less-than
   // vector is a prefix; both encode by OR-ing cell indices.
   always_comb begin
      old_idx   = '0;
      bound_idx = lt_ff[CAPACITY-1] ? CNT_W'(CAPACITY) : '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (key_match_ff[i]) begin
            old_idx = old_idx | CNT_W'(i);
         end
         if (lt_prev[i] && !lt_ff[i]) begin
            bound_idx = bound_idx | CNT_W'(i);
         end
      end
   end

   always_comb begin
      status    = ST_OK;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      hit_found = 1'b0;
      case (func_ff)
         FUNC_INSERT: begin
            if (key_hit) begin
               status = ST_PRESENT;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (key_hit) begin
               do_rem = 1'b1;
            end else begin
               status = ST_ABSENT;
            end
         end
         FUNC_REPLACE: begin
            if (new_hit) begin
               status = ST_PRESENT;
            end else if (key_hit) begin
               do_rem = 1'b1;
               do_ins = 1'b1;
            end else begin
               status = ST_ABSENT;
            end
         end
         FUNC_SEARCH: begin
            if (key_hit) begin
               hit_found = 1'b1;
            end else begin
               status = ST_ABSENT;
            end
         end
         default: begin
            status = ST_ABSENT;
         end
      endcase
   end

   // A plain insert acts as if the removed slot sat at the end; a plain
   // remove acts as if the insert slot sat at the end.
   assign rem_idx        = do_rem ? old_idx : count_ff;
   assign ins_idx        = do_ins ? bound_idx : count_ff;
   assign rem_before_ins = (rem_idx < ins_idx);

   always_comb begin
      count_in = count_ff;
      if (do_ins && !do_rem) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem && !do_ins) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // ---------------- cell update ----------------
   for (genvar g = 0; g < CAPACITY; g++) begin : g_src
      if (g + 1 < CAPACITY) begin : g_up
         assign up_src[g] = entries_ff[g+1];
      end else begin : g_up_last
         assign up_src[g] = entries_ff[g];
      end
      if (g > 0) begin : g_dn
         assign dn_src[g] = entries_ff[g-1];
      end else begin : g_dn_first
         assign dn_src[g] = entries_ff[g];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (rem_before_ins) begin
            // Cells between the removed slot and the insert slot move down.
            if (CNT_W'(i) < rem_idx) begin
               entries_in[i] = entries_ff[i];
            end else if (CNT_W'(i + 1) < ins_idx) begin
               entries_in[i] = up_src[i];
            end else if ((CNT_W'(i + 1) == ins_idx) && do_ins) begin
               entries_in[i] = key_ff;
            end
         end else begin
            // Cells between the insert slot and the removed slot move up.
            if (CNT_W'(i) < ins_idx) begin
               entries_in[i] = entries_ff[i];
            end else if ((CNT_W'(i) == ins_idx) && do_ins) begin
               entries_in[i] = key_ff;
            end else if (CNT_W'(i) <= rem_idx) begin
               entries_in[i] = dn_src[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (do_ins || do_rem)) begin
         entries_ff <= entries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // ---------------- result register ----------------
   assign pos_ext = hit_found ? EXT_W'(old_idx) : '0;
   assign cnt_ext = EXT_W'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff   <= status;
         rsp_found_ff    <= hit_found;
         rsp_position_ff <= pos_ext[POSITION_W-1:0];
         rsp_count_ff    <= cnt_ext[COUNT_W-1:0];
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

   // ---------------- assertions ----------------
   always_comb begin
      sorted_ok = 1'b1;
      for (int i = 0; i + 1 < CAPACITY; i++) begin
         if ((CNT_W'(i + 1) < count_ff) && !(entries_ff[i] < entries_ff[i+1])) begin
            sorted_ok = 1'b0;
         end
      end
   end

   `SUST_ASSERT_IMPLY(a_live_sorted, 1'b1, sorted_ok)
   `SUST_ASSERT_IMPLY(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SUST_ASSERT_IMPLY(a_key_unique, cmd.commit, $onehot0(key_match_ff))
   `SUST_ASSERT_NEXT(a_count_held, cmd.commit && !do_ins && !do_rem, $stable(count_ff))

endmodule

>>> hw/rtl/sorted_unique_set_table.sv
// ----------------------------------------------------------------------------
// Sorted unique set table
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order and
// serves insert, remove, replace and search requests, one result per item.
//
// The request channel (req_) carries func, value and new_value; an item is
// taken when req_valid is high and req_stall is low. The result channel
// (rsp_) returns status, found, position and count under the same rule.
// In the cycle an item is taken, the value is compared against every entry
// in parallel and the compare results are registered; in the commit step the
// controller commits the shift of the table cells and loads the result
// register, and the result then shows on rsp_valid. The next item can be taken
// in the cycle the result shows; no new item is taken while one is in commit.
// If the receiver stalls, the result register holds its item and the next
// request waits in the commit step until that register frees up.
// Synchronous reset empties the set (count zero) and clears the result valid;
// entry storage is not cleared, since only entries below the count are used.
// ----------------------------------------------------------------------------
module sorted_unique_set_table #(
   parameter int CAPACITY = sust_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sust_pkg::FUNC_W-1:0]      req_func,
   input  sust_pkg::value_type              req_value,
   input  sust_pkg::value_type              req_new_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sust_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_found,
   output logic [sust_pkg::POSITION_W-1:0]  rsp_position,
   output logic [sust_pkg::COUNT_W-1:0]     rsp_count
);
   import sust_pkg::*;

   // Commands from the sequencer; the datapath reports nothing back, since
   // every decision about the table is local to it.
   cmd_type cmd;

   // The controller owns both handshakes and decides when an item is taken
   // and when its result may be committed.
   sust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the table, the count and the result register.
   sust_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_func      (req_func),
      .req_value     (req_value),
      .req_new_value (req_new_value),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count)
   );

endmodule
